>>> rtl/core/tfn_pkg.sv
// Shared constants and width helpers for the triangle face normal unit.
// No dependencies; every other file in rtl/core imports this package.
package tfn_pkg;

   localparam int DEF_COORD_WIDTH      = 16;
   localparam int DEF_NORMAL_FRAC_BITS = 15;
   localparam int LIMIT_WIDTH          = 32;
   localparam int MAG_LIMIT_BITS       = 62;
   localparam int SHIFT_BITS           = 3;

   // magnitude width of one cross product component
   function automatic int mag_width(input int cw);
      return 2 * cw + 3;
   endfunction

   // magnitude width after pre-scaling of very long cross products
   function automatic int red_width(input int cw);
      return (mag_width(cw) > MAG_LIMIT_BITS) ? MAG_LIMIT_BITS : mag_width(cw);
   endfunction

   // width of the integer square root; the squared sum uses twice this
   function automatic int root_width(input int cw);
      return red_width(cw) + 1;
   endfunction

endpackage

>>> rtl/core/tfn_front.sv
// Front pipeline: edges, cross product, magnitudes, squared length and degenerate test.
// Depends on tfn_pkg.
module tfn_front
   import tfn_pkg::*;
#(
   parameter  int COORD_WIDTH = DEF_COORD_WIDTH,
   localparam int SW          = red_width(COORD_WIDTH),
   localparam int QW          = 2 * root_width(COORD_WIDTH),
   localparam int SDW         = 3 * SW + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] in_vert [9],
   input  logic [LIMIT_WIDTH-1:0]        limit,
   output logic                          out_valid,
   output logic [QW-1:0]                 out_sum,
   output logic                          out_degen,
   output logic [SDW-1:0]                out_side
);

   localparam int EW        = COORD_WIDTH + 1;
   localparam int PW        = 2 * EW;
   localparam int MW        = mag_width(COORD_WIDTH);
   localparam int SHIFT_MAX = (MW > MAG_LIMIT_BITS) ? MW - MAG_LIMIT_BITS : 0;
   localparam int H         = (SW + 1) / 2;
   localparam int HI        = SW - H;
   localparam int CMPW      = (QW > LIMIT_WIDTH) ? QW : LIMIT_WIDTH;
   localparam int NSTG      = 9;

   logic [NSTG-1:0] vld_ff, vld_in;

   logic signed [EW-1:0] e1_ff [3], e2_ff [3], e1_in [3], e2_in [3];
   logic signed [PW-1:0] p_ff [6], p_in [6];
   logic signed [MW-1:0] n_ff [3], n_in [3];
   logic [MW-1:0]        mag4_ff [3], mag4_in [3];
   logic [2:0]           neg4_ff;
   logic [SW-1:0]        mag5_ff [3], mag5_in [3];
   logic [2:0]           neg5_ff;
   logic                 big5_ff, big6_ff, big7_ff, big8_ff;
   logic [SHIFT_BITS-1:0] shift_amt;
   logic [2*HI-1:0]      hh_ff [3], hh_in [3];
   logic [SW-1:0]        hl_ff [3], hl_in [3];
   logic [2*H-1:0]       ll_ff [3], ll_in [3];
   logic [QW-1:0]        sq_ff [3], sq_in [3];
   logic [QW-1:0]        sum8_ff, sum9_ff;
   logic                 degen9_ff, degen9_in;
   logic [SDW-1:0]       side_ff [4];

   assign vld_in = {vld_ff[NSTG-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EW'(in_vert[3+i]) - EW'(in_vert[i]);
         e2_in[i] = EW'(in_vert[6+i]) - EW'(in_vert[i]);
      end
      p_in[0] = e1_ff[1] * e2_ff[2];
      p_in[1] = e1_ff[2] * e2_ff[1];
      p_in[2] = e1_ff[2] * e2_ff[0];
      p_in[3] = e1_ff[0] * e2_ff[2];
      p_in[4] = e1_ff[0] * e2_ff[1];
      p_in[5] = e1_ff[1] * e2_ff[0];
      for (int i = 0; i < 3; i++) begin
         n_in[i]    = MW'(p_ff[2*i]) - MW'(p_ff[2*i+1]);
         mag4_in[i] = n_ff[i][MW-1] ? $unsigned(-n_ff[i]) : $unsigned(n_ff[i]);
      end
   end

   // scale down cross products that do not fit the root datapath
   if (SHIFT_MAX > 0) begin : g_norm
      logic [MW-1:0] mag_or;
      assign mag_or = mag4_ff[0] | mag4_ff[1] | mag4_ff[2];
      always_comb begin
         shift_amt = '0;
         for (int j = 1; j <= SHIFT_MAX; j++) begin
            if (mag_or[MAG_LIMIT_BITS-1+j]) shift_amt = SHIFT_BITS'(j);
         end
      end
   end else begin : g_nonorm
      assign shift_amt = '0;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag5_in[i] = SW'(mag4_ff[i] >> shift_amt);
         hh_in[i]   = mag5_ff[i][SW-1:H] * mag5_ff[i][SW-1:H];
         hl_in[i]   = mag5_ff[i][SW-1:H] * mag5_ff[i][H-1:0];
         ll_in[i]   = mag5_ff[i][H-1:0] * mag5_ff[i][H-1:0];
         sq_in[i]   = (QW'(hh_ff[i]) << (2 * H)) + (QW'(hl_ff[i]) << (H + 1))
                    + QW'(ll_ff[i]);
      end
      degen9_in = !big8_ff && (CMPW'(sum8_ff) <= CMPW'(limit));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ff      <= e1_in;
         e2_ff      <= e2_in;
         p_ff       <= p_in;
         n_ff       <= n_in;
         mag4_ff    <= mag4_in;
         for (int i = 0; i < 3; i++) neg4_ff[i] <= n_ff[i][MW-1];
         mag5_ff    <= mag5_in;
         neg5_ff    <= neg4_ff;
         big5_ff    <= (shift_amt != '0);
         hh_ff      <= hh_in;
         hl_ff      <= hl_in;
         ll_ff      <= ll_in;
         side_ff[0] <= {neg5_ff, mag5_ff[2], mag5_ff[1], mag5_ff[0]};
         big6_ff    <= big5_ff;
         sq_ff      <= sq_in;
         side_ff[1] <= side_ff[0];
         big7_ff    <= big6_ff;
         sum8_ff    <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         side_ff[2] <= side_ff[1];
         big8_ff    <= big7_ff;
         sum9_ff    <= sum8_ff;
         degen9_ff  <= degen9_in;
         side_ff[3] <= side_ff[2];
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_sum   = sum9_ff;
   assign out_degen = degen9_ff;
   assign out_side  = side_ff[3];

endmodule

>>> rtl/core/tfn_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a tag carried alongside.
// Depends on tfn_pkg.
module tfn_isqrt
   import tfn_pkg::*;
#(
   parameter int RW = root_width(DEF_COORD_WIDTH),
   parameter int TW = 3 * red_width(DEF_COORD_WIDTH) + 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_num,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [TW-1:0]   out_tag
);

   localparam int QW = 2 * RW;

   logic [RW-1:0] vld_ff, vld_in;
   logic [QW-1:0] num_ff [RW];
   logic [QW-1:0] res_ff [RW];
   logic [TW-1:0] tag_ff [RW];

   assign vld_in = {vld_ff[RW-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar i = 0; i < RW; i++) begin : g_step
      localparam int B = 2 * (RW - 1 - i);
      logic [QW-1:0] num_prev, res_prev, trial, num_in, res_in;
      logic [TW-1:0] tag_prev;

      if (i == 0) begin : g_first
         assign num_prev = in_num;
         assign res_prev = '0;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign num_prev = num_ff[i-1];
         assign res_prev = res_ff[i-1];
         assign tag_prev = tag_ff[i-1];
      end

      always_comb begin
         trial = res_prev + (QW'(1) << B);
         if (num_prev >= trial) begin
            num_in = num_prev - trial;
            res_in = (res_prev >> 1) + (QW'(1) << B);
         end else begin
            num_in = num_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            num_ff[i] <= num_in;
            res_ff[i] <= res_in;
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = res_ff[RW-1][RW-1:0];
   assign out_tag   = tag_ff[RW-1];

endmodule

>>> rtl/core/tfn_div.sv
// Pipelined restoring divider for the three normal components, one quotient bit per stage,
// followed by sign and degenerate selection. Depends on tfn_pkg.
module tfn_div
   import tfn_pkg::*;
#(
   parameter  int SW  = red_width(DEF_COORD_WIDTH),
   parameter  int FB  = DEF_NORMAL_FRAC_BITS,
   localparam int RW  = SW + 1,
   localparam int SDW = 3 * SW + 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [RW-1:0]      in_root,
   input  logic [SDW-1:0]     in_side,
   input  logic               in_degen,
   output logic               out_valid,
   output logic signed [FB:0] out_norm [3],
   output logic               out_degen
);

   localparam int DW = RW + FB;
   localparam logic [FB:0] SCALE = {1'b0, {FB{1'b1}}};

   logic [FB+1:0] vld_ff, vld_in;
   logic [DW-1:0] rem_ff [FB+1][3];
   logic [FB-1:0] q_ff   [FB+1][3];
   logic [RW-1:0] r_ff   [FB+1];
   logic [2:0]    neg_ff [FB+1];
   logic          dg_ff  [FB+1];
   logic [FB:0]   norm_ff [3], norm_in [3];
   logic          dgo_ff;

   assign vld_in = {vld_ff[FB:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // prepare numerators mag * (2^FB - 1) and a nonzero divisor
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= (DW'(in_side[i*SW +: SW]) << FB) - DW'(in_side[i*SW +: SW]);
            q_ff[0][i]   <= '0;
         end
         r_ff[0]   <= (in_root == '0) ? RW'(1) : in_root;
         neg_ff[0] <= in_side[SDW-1 -: 3];
         dg_ff[0]  <= in_degen;
      end
   end

   for (genvar j = 0; j < FB; j++) begin : g_step
      localparam int B = FB - 1 - j;
      logic [DW-1:0] dvs;
      logic [DW-1:0] rem_in [3];
      logic [FB-1:0] q_in [3];

      assign dvs = DW'(r_ff[j]) << B;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[j][i] >= dvs) begin
               rem_in[i] = rem_ff[j][i] - dvs;
               q_in[i]   = q_ff[j][i] | (FB'(1) << B);
            end else begin
               rem_in[i] = rem_ff[j][i];
               q_in[i]   = q_ff[j][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j+1] <= rem_in;
            q_ff[j+1]   <= q_in;
            r_ff[j+1]   <= r_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            dg_ff[j+1]  <= dg_ff[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dg_ff[FB]) begin
            norm_in[i] = (i == 2) ? SCALE : '0;
         end else if (neg_ff[FB][i]) begin
            norm_in[i] = -{1'b0, q_ff[FB][i]};
         end else begin
            norm_in[i] = {1'b0, q_ff[FB][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         norm_ff <= norm_in;
         dgo_ff  <= dg_ff[FB];
      end
   end

   assign out_valid = vld_ff[FB+1];
   for (genvar i = 0; i < 3; i++) begin : g_out
      assign out_norm[i] = $signed(norm_ff[i]);
   end
   assign out_degen = dgo_ff;

endmodule

>>> rtl/core/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit: limit register, stall control, pipeline.
// Depends on tfn_pkg, tfn_front, tfn_isqrt and tfn_div.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_a_x .. req_c_z
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_norm_x/y/z, rsp_degenerate
//   csr     | in        | csr_valid / csr_ready  | csr_wdata (degenerate limit)
//
// One request per cycle while the response is not stalled; the root width is 36 at 16-bit
// coordinates, and most of the depth comes from the one-bit-per-stage root and divider pipelines.
// Reset clears all stage valid bits and the limit to zero.
// A stalled response freezes the whole pipeline; req_stall follows rsp_stall then.
module triangle_face_normal_unit
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH      = DEF_COORD_WIDTH,
   parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_WIDTH-1:0]      req_a_x,
   input  logic signed [COORD_WIDTH-1:0]      req_a_y,
   input  logic signed [COORD_WIDTH-1:0]      req_a_z,
   input  logic signed [COORD_WIDTH-1:0]      req_b_x,
   input  logic signed [COORD_WIDTH-1:0]      req_b_y,
   input  logic signed [COORD_WIDTH-1:0]      req_b_z,
   input  logic signed [COORD_WIDTH-1:0]      req_c_x,
   input  logic signed [COORD_WIDTH-1:0]      req_c_y,
   input  logic signed [COORD_WIDTH-1:0]      req_c_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [NORMAL_FRAC_BITS:0]   rsp_norm_x,
   output logic signed [NORMAL_FRAC_BITS:0]   rsp_norm_y,
   output logic signed [NORMAL_FRAC_BITS:0]   rsp_norm_z,
   output logic                               rsp_degenerate,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [LIMIT_WIDTH-1:0]             csr_wdata
);

   localparam int SW  = red_width(COORD_WIDTH);
   localparam int RW  = root_width(COORD_WIDTH);
   localparam int SDW = 3 * SW + 3;
   localparam int TW  = SDW + 1;
   localparam logic [NORMAL_FRAC_BITS:0] SCALE = {1'b0, {NORMAL_FRAC_BITS{1'b1}}};

   logic [LIMIT_WIDTH-1:0]           limit_ff;
   logic                             advance;
   logic signed [COORD_WIDTH-1:0]    vert [9];
   logic                             fr_valid, fr_degen;
   logic [2*RW-1:0]                  fr_sum;
   logic [SDW-1:0]                   fr_side;
   logic                             sq_valid;
   logic [RW-1:0]                    sq_root;
   logic [TW-1:0]                    sq_tag;
   logic signed [NORMAL_FRAC_BITS:0] norm [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_wdata;
      end
   end

   // hold everything while the response register is full and stalled
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign vert[0] = req_a_x;
   assign vert[1] = req_a_y;
   assign vert[2] = req_a_z;
   assign vert[3] = req_b_x;
   assign vert[4] = req_b_y;
   assign vert[5] = req_b_z;
   assign vert[6] = req_c_x;
   assign vert[7] = req_c_y;
   assign vert[8] = req_c_z;

   tfn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_vert   (vert),
      .limit     (limit_ff),
      .out_valid (fr_valid),
      .out_sum   (fr_sum),
      .out_degen (fr_degen),
      .out_side  (fr_side)
   );

   tfn_isqrt #(.RW(RW), .TW(TW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fr_valid),
      .in_num    (fr_sum),
      .in_tag    ({fr_degen, fr_side}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   tfn_div #(.SW(SW), .FB(NORMAL_FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_tag[SDW-1:0]),
      .in_degen  (sq_tag[TW-1]),
      .out_valid (rsp_valid),
      .out_norm  (norm),
      .out_degen (rsp_degenerate)
   );

   assign rsp_norm_x = norm[0];
   assign rsp_norm_y = norm[1];
   assign rsp_norm_z = norm[2];

   a_degen_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_norm_x == '0 && rsp_norm_y == '0 && rsp_norm_z == $signed(SCALE))
      else $error("degenerate response without fixed normal");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_x != $signed(~SCALE) && rsp_norm_y != $signed(~SCALE)
                    && rsp_norm_z != $signed(~SCALE))
      else $error("normal component outside unit range");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response stalled");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(sq_root) && $stable(fr_sum))
      else $error("pipeline moved during stall");

endmodule

>>> tb/tb_triangle_face_normal_unit.sv
// Self-checking testbench for triangle_face_normal_unit: drives triangles, predicts
// the unit normal and degenerate flag, checks every response in order.
// Depends on tfn_pkg and the RTL of triangle_face_normal_unit.
`timescale 1ns / 1ps

module tb_triangle_face_normal_unit
   import tfn_pkg::*;
();

   localparam int CW = DEF_COORD_WIDTH;
   localparam int FB = DEF_NORMAL_FRAC_BITS;
   localparam longint SCALE = (64'd1 << FB) - 1;
   localparam int LATENCY = 9 + root_width(CW) + FB + 2;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD = 400;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [FB:0] comp_type;
   typedef coord_type triangle_type[9];
   typedef struct packed {
      comp_type nx;
      comp_type ny;
      comp_type nz;
      logic     degen;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_type req_a_x = '0, req_a_y = '0, req_a_z = '0;
   coord_type req_b_x = '0, req_b_y = '0, req_b_z = '0;
   coord_type req_c_x = '0, req_c_y = '0, req_c_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   comp_type rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic rsp_degenerate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIMIT_WIDTH-1:0] csr_wdata = '0;

   logic [LIMIT_WIDTH-1:0] limit_shadow = '0;
   normal_type pending_normals[$];
   int failures = 0;
   int sent = 0;
   int checked = 0;
   int degen_seen = 0;
   int idle_cycles = 0;
   bit sender_gaps = 1'b0;
   bit receiver_stalls = 1'b0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stall_left = 0;

   triangle_face_normal_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .req_c_x(req_c_x), .req_c_y(req_c_y), .req_c_z(req_c_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_norm_x(rsp_norm_x), .rsp_norm_y(rsp_norm_y), .rsp_norm_z(rsp_norm_z),
      .rsp_degenerate(rsp_degenerate),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic normal_type face_normal(input triangle_type t, input logic [31:0] lim);
      longint e1x, e1y, e1z, e2x, e2y, e2z;
      longint n[3];
      logic [127:0] mag[3];
      logic [127:0] sum, rem, root, bitv, trial, q;
      normal_type res;
      comp_type c[3];
      e1x = longint'(t[3]) - longint'(t[0]);
      e1y = longint'(t[4]) - longint'(t[1]);
      e1z = longint'(t[5]) - longint'(t[2]);
      e2x = longint'(t[6]) - longint'(t[0]);
      e2y = longint'(t[7]) - longint'(t[1]);
      e2z = longint'(t[8]) - longint'(t[2]);
      n[0] = e1y * e2z - e1z * e2y;
      n[1] = e1z * e2x - e1x * e2z;
      n[2] = e1x * e2y - e1y * e2x;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
         sum += mag[i] * mag[i];
      end
      if (sum <= 128'(lim)) begin
         res.nx = '0;
         res.ny = '0;
         res.nz = comp_type'(SCALE);
         res.degen = 1'b1;
         return res;
      end
      rem = sum;
      root = '0;
      bitv = 128'd1 << 126;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         trial = root + bitv;
         if (rem >= trial) begin
            rem -= trial;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (root == 0) root = 1;
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 128'(SCALE)) / root;
         if (q > 128'(SCALE)) q = 128'(SCALE);
         c[i] = (n[i] < 0) ? comp_type'(-q) : comp_type'(q);
      end
      res.nx = c[0];
      res.ny = c[1];
      res.nz = c[2];
      res.degen = 1'b0;
      return res;
   endfunction

   // receiver: stall pattern and long hold
   always @(negedge clock) begin
      if (hold_served < hold_asked) begin
         hold_served = hold_served + 1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_stalls && $urandom_range(3) == 0) begin
         stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      normal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
         end else begin
            want = pending_normals.pop_front();
            checked++;
            if (want.degen) degen_seen++;
            if (rsp_norm_x !== want.nx) begin
               $error("norm_x expected %0d got %0d", want.nx, rsp_norm_x);
               failures++;
            end
            if (rsp_norm_y !== want.ny) begin
               $error("norm_y expected %0d got %0d", want.ny, rsp_norm_y);
               failures++;
            end
            if (rsp_norm_z !== want.nz) begin
               $error("norm_z expected %0d got %0d", want.nz, rsp_norm_z);
               failures++;
            end
            if (rsp_degenerate !== want.degen) begin
               $error("degenerate expected %0d got %0d", want.degen, rsp_degenerate);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_triangle(input triangle_type t);
      @(negedge clock);
      req_a_x = t[0]; req_a_y = t[1]; req_a_z = t[2];
      req_b_x = t[3]; req_b_y = t[4]; req_b_z = t[5];
      req_c_x = t[6]; req_c_y = t[7]; req_c_z = t[8];
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_normals = {pending_normals, face_normal(t, limit_shadow)};
      sent++;
      if (sender_gaps && $urandom_range(3) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2))
            @(negedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      limit_shadow = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   // well-formed shapes mixed with noise
   function automatic triangle_type random_triangle();
      triangle_type t;
      int kind;
      int s;
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) t[i] = rand_coord();
      case (kind)
         0, 1, 2: begin
         end
         3, 4: begin
            s = 1 << $urandom_range(8);
            for (int i = 3; i < 9; i++)
               t[i] = coord_type'(int'(t[i % 3]) + $urandom_range(2 * s) - s);
         end
         5: begin
            s = $urandom_range(3) - 1;
            for (int i = 0; i < 3; i++)
               t[6 + i] = coord_type'(int'(t[i]) + s * (int'(t[3 + i]) - int'(t[i])));
         end
         6: begin
            for (int i = 0; i < 3; i++) t[3 + i] = t[i];
         end
         7: begin
            for (int i = 0; i < 9; i++)
               t[i] = $urandom_range(1) ? coord_type'(16'sh7fff) : coord_type'(16'sh8000);
         end
         default: begin
            for (int i = 0; i < 9; i++) t[i] = coord_type'($urandom_range(6) - 3);
         end
      endcase
      return t;
   endfunction

   task automatic test_directed;
      triangle_type t;
      t = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
      send_triangle(t);
      t = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
      send_triangle(t);
      t = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
      send_triangle(t);
      t = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
      send_triangle(t);
      t = '{0, 0, 0, 2, 2, 2, 4, 4, 4};
      send_triangle(t);
      t = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
      send_triangle(t);
      t = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
      send_triangle(t);
      t = '{-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767};
      send_triangle(t);
      t = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768};
      send_triangle(t);
      t = '{-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768};
      send_triangle(t);
      t = '{0, 0, 0, 3, 4, 0, -4, 3, 0};
      send_triangle(t);
      t = '{1, 2, 3, 2, 3, 5, 3, 5, 7};
      send_triangle(t);
      t = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
      send_triangle(t);
      t = '{0, 0, 0, 32767, 0, 0, 0, 0, 32767};
      send_triangle(t);
      t = '{0, 0, 0, -32768, 0, 0, 0, -32768, 0};
      send_triangle(t);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_triangle(random_triangle());
   endtask

   task automatic test_backpressure;
      sender_gaps = 1'b0;
      hold_asked = hold_asked + 1;
      test_random(LATENCY * 2);
      sender_gaps = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      write_limit(32'd1);
      test_directed();
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      test_random(400);
      write_limit(32'd100);
      test_random(300);
      test_backpressure();
      write_limit(32'hffffffff);
      test_directed();
      test_random(300);
      write_limit($urandom);
      receiver_stalls = 1'b0;
      sender_gaps = 1'b0;
      test_random(200);
      write_limit(32'd0);
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      test_random(250);
      drain();
      $display("covered %0d triangles, %0d responses checked, %0d degenerate",
               sent, checked, degen_seen);
      $display("limits 0, 1, 100, max and random; random gaps, stalls and one long hold");
      if (failures == 0 && pending_normals.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
